>>> design/assert_macros.svh
// Assertion macros shared by the staged fan controller RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SFHC_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define SFHC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/sfhc_pkg.sv
// Package for the staged fan controller: payload and configuration types,
// register indexes, level codes and the speed table. No dependencies.
`default_nettype none

package sfhc_pkg;

	localparam int TEMP_W      = 15;
	localparam int GAP_W       = 11;
	localparam int DWELL_W     = 32;
	localparam int NOW_W       = 32;
	localparam int LEVEL_W     = 3;
	localparam int SPEED_W     = 7;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int TICK_WIDTH_DEF = 32;

	typedef logic [LEVEL_W-1:0] level_t;

	localparam level_t LEVEL_IDLE   = 3'd0;
	localparam level_t LEVEL_LOW    = 3'd1;
	localparam level_t LEVEL_MEDIUM = 3'd2;
	localparam level_t LEVEL_HIGH   = 3'd3;
	localparam level_t LEVEL_MAX    = 3'd4;

	localparam logic signed [TEMP_W-1:0] UP_LOW_RST    = 15'sd2800;
	localparam logic signed [TEMP_W-1:0] UP_MEDIUM_RST = 15'sd3200;
	localparam logic signed [TEMP_W-1:0] UP_HIGH_RST   = 15'sd3600;
	localparam logic signed [TEMP_W-1:0] UP_MAX_RST    = 15'sd4000;
	localparam logic [GAP_W-1:0]         DOWN_GAP_RST  = 11'd200;
	localparam logic [DWELL_W-1:0]       DWELL_RST     = 32'd10000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UP_LOW    = 3'd0,
		REG_UP_MEDIUM = 3'd1,
		REG_UP_HIGH   = 3'd2,
		REG_UP_MAX    = 3'd3,
		REG_DOWN_GAP  = 3'd4,
		REG_DWELL     = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature;
		logic                     temp_valid;
		logic                     manual_mode;
		logic [NOW_W-1:0]         now_ticks;
	} sample_t;

	typedef struct packed {
		level_t             fan_level;
		logic [SPEED_W-1:0] speed_percent;
	} result_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] up_low;
		logic signed [TEMP_W-1:0] up_medium;
		logic signed [TEMP_W-1:0] up_high;
		logic signed [TEMP_W-1:0] up_max;
		logic [GAP_W-1:0]         down_gap;
		logic [DWELL_W-1:0]       dwell_ticks;
	} cfg_t;

	function automatic logic [SPEED_W-1:0] speed_of(input level_t level);
		logic [SPEED_W-1:0] speed;
		unique case (level)
			LEVEL_IDLE:   speed = 7'd0;
			LEVEL_LOW:    speed = 7'd25;
			LEVEL_MEDIUM: speed = 7'd50;
			LEVEL_HIGH:   speed = 7'd75;
			LEVEL_MAX:    speed = 7'd100;
			default:      speed = 7'd0;
		endcase
		return speed;
	endfunction

endpackage

`default_nettype wire

>>> design/sfhc_cfg_regs.sv
// Configuration register file for the staged fan controller.
// Depends on sfhc_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module sfhc_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write_en,
	input  wire logic [sfhc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sfhc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output sfhc_pkg::cfg_t                          cfg
);

	sfhc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.up_low      <= sfhc_pkg::UP_LOW_RST;
			cfg_q.up_medium   <= sfhc_pkg::UP_MEDIUM_RST;
			cfg_q.up_high     <= sfhc_pkg::UP_HIGH_RST;
			cfg_q.up_max      <= sfhc_pkg::UP_MAX_RST;
			cfg_q.down_gap    <= sfhc_pkg::DOWN_GAP_RST;
			cfg_q.dwell_ticks <= sfhc_pkg::DWELL_RST;
		end else if (cfg_write_en) begin
			unique case (sfhc_pkg::cfg_reg_t'(cfg_index))
				sfhc_pkg::REG_UP_LOW:
					cfg_q.up_low <= $signed(cfg_wdata[sfhc_pkg::TEMP_W-1:0]);
				sfhc_pkg::REG_UP_MEDIUM:
					cfg_q.up_medium <= $signed(cfg_wdata[sfhc_pkg::TEMP_W-1:0]);
				sfhc_pkg::REG_UP_HIGH:
					cfg_q.up_high <= $signed(cfg_wdata[sfhc_pkg::TEMP_W-1:0]);
				sfhc_pkg::REG_UP_MAX:
					cfg_q.up_max <= $signed(cfg_wdata[sfhc_pkg::TEMP_W-1:0]);
				sfhc_pkg::REG_DOWN_GAP:
					cfg_q.down_gap <= cfg_wdata[sfhc_pkg::GAP_W-1:0];
				sfhc_pkg::REG_DWELL:
					cfg_q.dwell_ticks <= cfg_wdata[sfhc_pkg::DWELL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> design/sfhc_step.sv
// Next-level decision for the staged fan controller: up/down hysteresis
// compares and the wrapping dwell check. Depends on sfhc_pkg.
`default_nettype none

module sfhc_step #(
	parameter int TICK_WIDTH = sfhc_pkg::TICK_WIDTH_DEF
) (
	input  wire sfhc_pkg::cfg_t                     cfg,
	input  wire sfhc_pkg::level_t                   level,
	input  wire logic [TICK_WIDTH-1:0]              entry_tick,
	input  wire logic signed [sfhc_pkg::TEMP_W-1:0] temperature,
	input  wire logic [sfhc_pkg::NOW_W-1:0]         now_ticks,
	output sfhc_pkg::level_t                        next_level,
	output logic [TICK_WIDTH-1:0]                   now_tick
);

	localparam int EXT_W = (TICK_WIDTH > sfhc_pkg::NOW_W) ? TICK_WIDTH : sfhc_pkg::NOW_W;
	localparam int CMP_W = sfhc_pkg::TEMP_W + 2;

	logic [EXT_W-1:0]               now_ext;
	logic [TICK_WIDTH-1:0]          elapsed;
	logic                           dwell_done;
	logic signed [sfhc_pkg::TEMP_W-1:0] up_thr;
	logic signed [sfhc_pkg::TEMP_W-1:0] entry_thr;
	logic signed [CMP_W-1:0]        temp_ext;
	logic signed [CMP_W-1:0]        down_at;
	logic                           go_up;
	logic                           go_down;

	assign now_ext    = EXT_W'(now_ticks);
	assign now_tick   = now_ext[TICK_WIDTH-1:0];
	assign elapsed    = now_tick - entry_tick;
	assign dwell_done = EXT_W'(elapsed) > EXT_W'(cfg.dwell_ticks);

	always_comb begin
		up_thr    = cfg.up_max;
		entry_thr = cfg.up_low;
		unique case (level)
			sfhc_pkg::LEVEL_IDLE: begin
				up_thr = cfg.up_low;
			end
			sfhc_pkg::LEVEL_LOW: begin
				up_thr    = cfg.up_medium;
				entry_thr = cfg.up_low;
			end
			sfhc_pkg::LEVEL_MEDIUM: begin
				up_thr    = cfg.up_high;
				entry_thr = cfg.up_medium;
			end
			sfhc_pkg::LEVEL_HIGH: begin
				up_thr    = cfg.up_max;
				entry_thr = cfg.up_high;
			end
			sfhc_pkg::LEVEL_MAX: begin
				entry_thr = cfg.up_max;
			end
			default: begin
			end
		endcase
	end

	assign temp_ext = {{2{temperature[sfhc_pkg::TEMP_W-1]}}, temperature};
	assign down_at  = $signed({{2{entry_thr[sfhc_pkg::TEMP_W-1]}}, entry_thr})
		- $signed({{(CMP_W-sfhc_pkg::GAP_W){1'b0}}, cfg.down_gap});

	assign go_up   = (level < sfhc_pkg::LEVEL_MAX) && (temperature > up_thr);
	assign go_down = (level >= sfhc_pkg::LEVEL_LOW) && (level <= sfhc_pkg::LEVEL_MAX)
		&& (temp_ext < down_at) && dwell_done;

	always_comb begin
		next_level = level;
		if (go_up) begin
			next_level = level + sfhc_pkg::LEVEL_LOW;
		end else if (go_down) begin
			next_level = level - sfhc_pkg::LEVEL_LOW;
		end
	end

endmodule

`default_nettype wire

>>> design/staged_fan_hysteresis_controller_core.sv
// Staged fan controller top level: input register, level state, result register.
// Depends on sfhc_pkg, sfhc_cfg_regs, sfhc_step and assert_macros.svh.
//
// Five-level fan controller (idle, low, medium, high, max) with hysteresis.
// Each sample transaction carries a temperature, a valid flag, a manual flag
// and the millisecond tick. Manual or invalid samples are dropped without a
// result. Otherwise the level steps up one when the temperature is above the
// current step's up threshold, or down one when it is below the level's entry
// threshold minus down_gap and more than dwell_ticks have passed since the
// last change (up wins when both hold); one result with the level and its
// speed percent follows. Throughput is one sample per cycle while results are
// taken or samples dropped: the level and entry tick are read, decided and
// written back in the same cycle that moves a sample from the input register
// to the result register. A result still waiting on result_ready holds the
// next kept sample in the input register.
// Configuration writes take effect at once and belong to idle periods.
`default_nettype none
`include "assert_macros.svh"

module staged_fan_hysteresis_controller_core #(
	parameter int TICK_WIDTH = sfhc_pkg::TICK_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            sample_valid,
	output logic                                 sample_ready,
	input  wire sfhc_pkg::sample_t               sample,
	output logic                                 result_valid,
	input  wire logic                            result_ready,
	output sfhc_pkg::result_t                    result,
	input  wire logic                            cfg_write_en,
	input  wire logic [sfhc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sfhc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	sfhc_pkg::cfg_t    cfg;
	sfhc_pkg::sample_t sample_s1;
	logic              valid_s1;
	logic              drop_s1;
	logic              advance_s1;
	sfhc_pkg::level_t  level_q;
	logic [TICK_WIDTH-1:0] entry_tick_q;
	sfhc_pkg::level_t  next_level;
	logic [TICK_WIDTH-1:0] now_tick;
	sfhc_pkg::result_t result_q;
	logic              result_valid_q;

	sfhc_cfg_regs u_cfg_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.cfg          (cfg)
	);

	sfhc_step #(
		.TICK_WIDTH (TICK_WIDTH)
	) u_step (
		.cfg         (cfg),
		.level       (level_q),
		.entry_tick  (entry_tick_q),
		.temperature (sample_s1.temperature),
		.now_ticks   (sample_s1.now_ticks),
		.next_level  (next_level),
		.now_tick    (now_tick)
	);

	assign drop_s1      = sample_s1.manual_mode || !sample_s1.temp_valid;
	assign advance_s1   = valid_s1 && (drop_s1 || !result_valid_q || result_ready);
	assign sample_ready = !valid_s1 || advance_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			sample_s1 <= sample;
		end
	end

	// Level state; update only on a sample that is kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= sfhc_pkg::LEVEL_IDLE;
			entry_tick_q <= '0;
		end else if (advance_s1 && !drop_s1 && (next_level != level_q)) begin
			level_q      <= next_level;
			entry_tick_q <= now_tick;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance_s1 && !drop_s1) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && !drop_s1) begin
			result_q.fan_level     <= next_level;
			result_q.speed_percent <= sfhc_pkg::speed_of(next_level);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`SFHC_ASSERT(a_level_range, level_q <= sfhc_pkg::LEVEL_MAX, "fan level out of range")
	`SFHC_ASSERT(a_result_speed,
		!result_valid_q || (result_q.speed_percent == sfhc_pkg::speed_of(result_q.fan_level)),
		"result speed does not match its level")
	`SFHC_ASSERT_NEXT(a_one_step, 1'b1,
		(level_q == $past(level_q)) || (level_q == $past(level_q) + sfhc_pkg::LEVEL_LOW)
		|| (level_q == $past(level_q) - sfhc_pkg::LEVEL_LOW),
		"fan level moved by more than one step")
	`SFHC_ASSERT_NEXT(a_drop_holds, advance_s1 && drop_s1,
		$stable(level_q) && $stable(entry_tick_q), "dropped sample changed the level state")
	`SFHC_ASSERT_NEXT(a_no_loss, result_valid_q && !result_ready,
		result_valid_q && $stable(result_q), "pending result was lost or changed")

endmodule

`default_nettype wire
